[rtl/cbpp_pkg.sv]
// Package for the cubic Bezier point plotter: screen geometry, field widths,
// codes and the fixed-point lerp helpers. Depends on nothing.
package cbpp_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int COORD_W  = 16;                 // signed Q8.8
  localparam int PARAM_W  = 17;                 // unsigned Q1.16, 1.0 = 2^16
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = DIFF_W + PARAM_W + 1;
  localparam int PIX_W    = 8;
  localparam int ADDR_W   = 13;
  localparam int ADDR_CALC_W = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_POINTS  = 4;

  localparam logic [PARAM_W-1:0] T_ONE = PARAM_W'(65536);

  // glyph codes
  localparam logic GLYPH_CURVE  = 1'b0;
  localparam logic GLYPH_MARKER = 1'b1;

  // input mode codes
  localparam logic MODE_CURVE = 1'b0;
  localparam logic MODE_MARK  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  step_t;   // floor((b-a)*t / 2^16)
  typedef logic        [PARAM_W-1:0] param_t;

  // floor((b - a) * t / 2^16); for t up to 1.0 the magnitude never exceeds |b - a|
  function automatic step_t lerp_step(input coord_t a, input coord_t b, input param_t t);
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    diff = DIFF_W'(b) - DIFF_W'(a);
    prod = PROD_W'(diff) * $signed({1'b0, t});
    return prod[DIFF_W+15:16];
  endfunction

  // a + step stays between a and b, so it fits a coordinate again
  function automatic coord_t lerp_add(input coord_t a, input step_t s);
    logic signed [DIFF_W-1:0] sum;
    sum = DIFF_W'(a) + s;
    return sum[COORD_W-1:0];
  endfunction

endpackage

[rtl/cubic_bezier_point_plotter_unit.sv]
// Top level of the cubic Bezier point plotter: nine-stage de Casteljau pipeline.
// Depends on cbpp_pkg.
//
// Usage
//   Load the four control points (signed Q8.8) over the cfg_ port while no item
//   is in flight: cfg_index 0..7 = p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y.
//   Each input item either evaluates the curve at t (in_tuser = 0) or marks one
//   control point (in_tuser = 1). Every item yields exactly one result item:
//   the pixel (truncated toward zero), an in-bounds flag, the cell address with
//   row 0 at the bottom of the screen, and the glyph code on out_tuser.
// Pipeline
//   Nine register stages from input to output. One item per cycle is sustained
//   while out_tready is high; each lerp level takes two stages (multiply, then
//   add), three levels deep.
// Reset
//   rst_n (synchronous, active low) empties the pipeline and clears the
//   control points to zero.
// Stall
//   Every stage has its own valid bit and loads when it is empty or the stage
//   after it moves, so bubbles are squeezed out and input keeps being taken
//   while the output waits, until the pipeline is full. Nothing is dropped.
module cubic_bezier_point_plotter_unit
  import cbpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,    // [16:0] curve_param, [18:17] point_select, rest 0
  input  logic                 in_tuser,    // [0] mode

  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [16] in_bounds,
                                            // [29:17] cell_address, rest 0
  output logic                 out_tuser,   // [0] glyph

  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam int NSTG = 9;

  // ---------------- control points ----------------
  coord_t pt_x_r [NUM_POINTS];
  coord_t pt_y_r [NUM_POINTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        pt_x_r[i] <= '0;
        pt_y_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index[0]) begin
        pt_y_r[cfg_index[2:1]] <= cfg_data;
      end else begin
        pt_x_r[cfg_index[2:1]] <= cfg_data;
      end
    end
  end

  // ---------------- flow control ----------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] stg_en;

  always_comb begin
    stg_en[NSTG-1] = ~vld_r[NSTG-1] | out_tready;
    for (int k = NSTG-2; k >= 0; k--) begin
      stg_en[k] = ~vld_r[k] | stg_en[k+1];
    end
  end

  assign in_tready = stg_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stg_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------- sideband carried down the pipe ----------------
  // mode to stage 7, select to stage 5, t to stage 4
  logic                       mode_r [NSTG-1];
  logic [1:0]                 sel_r  [6];
  param_t                     t_r    [5];

  param_t t_nxt;
  always_comb begin
    t_nxt = in_tdata[PARAM_W-1:0];
    if (t_nxt[PARAM_W-1]) begin
      t_nxt = T_ONE;                        // t above one saturates
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      mode_r[0] <= in_tuser;
      sel_r[0]  <= in_tdata[PARAM_W+1:PARAM_W];
      t_r[0]    <= t_nxt;
    end
    for (int k = 1; k < NSTG-1; k++) begin
      if (stg_en[k]) begin
        mode_r[k] <= mode_r[k-1];
      end
    end
    for (int k = 1; k < 6; k++) begin
      if (stg_en[k]) begin
        sel_r[k] <= sel_r[k-1];
      end
    end
    for (int k = 1; k < 5; k++) begin
      if (stg_en[k]) begin
        t_r[k] <= t_r[k-1];
      end
    end
  end

  // ---------------- level 1: P0-P1, P1-P2, P2-P3 ----------------
  // index [axis][segment], axis 0 = x, 1 = y
  // the level-2 and level-3 step stages also carry the lerp start point, so the
  // add stage that follows uses the same item's operands
  step_t  s1_step_r [2][3];
  coord_t s2_lvl1_r [2][3];
  step_t  s3_step_r [2][2];
  coord_t s3_base_r [2][2];
  coord_t s4_lvl2_r [2][2];
  step_t  s5_step_r [2];
  coord_t s5_base_r [2];
  coord_t s6_pos_r  [2];

  step_t  s1_step_nxt [2][3];
  coord_t s2_lvl1_nxt [2][3];
  step_t  s3_step_nxt [2][2];
  coord_t s4_lvl2_nxt [2][2];
  step_t  s5_step_nxt [2];
  coord_t s6_pos_nxt  [2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s1_step_nxt[0][j] = lerp_step(pt_x_r[j], pt_x_r[j+1], t_r[0]);
      s1_step_nxt[1][j] = lerp_step(pt_y_r[j], pt_y_r[j+1], t_r[0]);
      s2_lvl1_nxt[0][j] = lerp_add(pt_x_r[j], s1_step_r[0][j]);
      s2_lvl1_nxt[1][j] = lerp_add(pt_y_r[j], s1_step_r[1][j]);
    end
    for (int a = 0; a < 2; a++) begin
      // level 2: between the level-1 points
      for (int j = 0; j < 2; j++) begin
        s3_step_nxt[a][j] = lerp_step(s2_lvl1_r[a][j], s2_lvl1_r[a][j+1], t_r[2]);
        s4_lvl2_nxt[a][j] = lerp_add(s3_base_r[a][j], s3_step_r[a][j]);
      end
      // level 3: final point on the curve
      s5_step_nxt[a] = lerp_step(s4_lvl2_r[a][0], s4_lvl2_r[a][1], t_r[4]);
    end
    // curve point, or the selected control point as it stands
    if (mode_r[5] == MODE_MARK) begin
      s6_pos_nxt[0] = pt_x_r[sel_r[5]];
      s6_pos_nxt[1] = pt_y_r[sel_r[5]];
    end else begin
      s6_pos_nxt[0] = lerp_add(s5_base_r[0], s5_step_r[0]);
      s6_pos_nxt[1] = lerp_add(s5_base_r[1], s5_step_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      s1_step_r <= s1_step_nxt;
    end
    if (stg_en[2]) begin
      s2_lvl1_r <= s2_lvl1_nxt;
    end
    if (stg_en[3]) begin
      s3_step_r <= s3_step_nxt;
      for (int a = 0; a < 2; a++) begin
        for (int j = 0; j < 2; j++) begin
          s3_base_r[a][j] <= s2_lvl1_r[a][j];
        end
      end
    end
    if (stg_en[4]) begin
      s4_lvl2_r <= s4_lvl2_nxt;
    end
    if (stg_en[5]) begin
      s5_step_r <= s5_step_nxt;
      for (int a = 0; a < 2; a++) begin
        s5_base_r[a] <= s4_lvl2_r[a][0];
      end
    end
    if (stg_en[6]) begin
      s6_pos_r <= s6_pos_nxt;
    end
  end

  // ---------------- stage 7: whole pixel and bounds ----------------
  logic signed [PIX_W-1:0] s7_px_r, s7_py_r;
  logic                    s7_inb_r;
  logic signed [PIX_W-1:0] s7_px_nxt, s7_py_nxt;
  logic                    s7_inb_nxt;
  logic        [COORD_W:0] trunc_x, trunc_y;

  always_comb begin
    // truncate toward zero: add 255 to negatives, then floor by 256
    trunc_x = {s6_pos_r[0][COORD_W-1], s6_pos_r[0]}
            + {{(COORD_W-7){1'b0}}, {8{s6_pos_r[0][COORD_W-1]}}};
    trunc_y = {s6_pos_r[1][COORD_W-1], s6_pos_r[1]}
            + {{(COORD_W-7){1'b0}}, {8{s6_pos_r[1][COORD_W-1]}}};
    s7_px_nxt  = trunc_x[COORD_W-1:8];
    s7_py_nxt  = trunc_y[COORD_W-1:8];
    s7_inb_nxt = ~s7_px_nxt[PIX_W-1] && ~s7_py_nxt[PIX_W-1]
              && ({1'b0, s7_px_nxt} < (PIX_W+1)'(SCREEN_WIDTH))
              && ({1'b0, s7_py_nxt} < (PIX_W+1)'(SCREEN_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (stg_en[7]) begin
      s7_px_r  <= s7_px_nxt;
      s7_py_r  <= s7_py_nxt;
      s7_inb_r <= s7_inb_nxt;
    end
  end

  // ---------------- stage 8: cell address, output register ----------------
  logic [ADDR_CALC_W-1:0] addr_calc;
  logic [31:0]            out_tdata_nxt;
  logic [31:0]            out_tdata_r;
  logic                   out_tuser_r;

  always_comb begin
    // row flipped so that y = 0 is the bottom line of the screen
    addr_calc = (ADDR_CALC_W'(SCREEN_HEIGHT - 1) - {{(ADDR_CALC_W-PIX_W){1'b0}}, s7_py_r})
              * ADDR_CALC_W'(SCREEN_WIDTH)
              + {{(ADDR_CALC_W-PIX_W){1'b0}}, s7_px_r};
    if (!s7_inb_r) begin
      addr_calc = '0;
    end
    out_tdata_nxt = {2'b00, addr_calc[ADDR_W-1:0], s7_inb_r, s7_py_r, s7_px_r};
  end

  always_ff @(posedge clk) begin
    if (stg_en[8]) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= (mode_r[7] == MODE_MARK) ? GLYPH_MARKER : GLYPH_CURVE;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
